[rtl/core/grid_component_labeler_defines.svh]
// ----------------------------------------------------------------------------
// grid component labeler assertion macros
// shared concurrent assertion forms for the labeler rtl
// ----------------------------------------------------------------------------
`ifndef GRID_COMPONENT_LABELER_DEFINES_SVH
`define GRID_COMPONENT_LABELER_DEFINES_SVH

// property holds at every clock edge out of reset
`define GCL_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("gcl assertion failed");

// consequent holds in the cycle after the antecedent
`define GCL_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("gcl assertion failed");

`endif

[rtl/core/gcl_pkg.sv]
// ----------------------------------------------------------------------------
// gcl_pkg
// types, codes and small tables of the grid component labeler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcl_pkg;

	localparam int COORD_W      = 6;
	localparam int LBL_W        = 13;
	localparam int DIM_W        = 7;
	localparam int CONN_W       = 2;
	localparam int DEF_MAX_COLS = 64;
	localparam int DEF_MAX_ROWS = 64;

	typedef enum logic [1:0] {
		OP_WRITE       = 2'd0,
		OP_LABEL       = 2'd1,
		OP_READ_LABEL  = 2'd2,
		OP_READ_REGION = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_WIDTH   = 2'd0,
		CFG_HEIGHT  = 2'd1,
		CFG_OPEN    = 2'd2,
		CFG_BLOCKED = 2'd3
	} cfg_idx_t;

	localparam logic [CONN_W-1:0] CONN_FOUR    = 2'd0;
	localparam logic [CONN_W-1:0] CONN_LIMITED = 2'd1;
	localparam logic [CONN_W-1:0] CONN_EIGHT   = 2'd2;

	localparam logic [1:0] DIR_NEG  = 2'd0;
	localparam logic [1:0] DIR_ZERO = 2'd1;
	localparam logic [1:0] DIR_POS  = 2'd2;

	typedef struct packed {
		op_t                operation;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               cell_value;
		logic [LBL_W-1:0]   region_id;
	} in_beat_t;

	typedef struct packed {
		logic               status;
		logic [LBL_W-1:0]   label;
		logic [LBL_W-1:0]   region_count;
		logic               region_value;
		logic [COORD_W-1:0] top_col;
		logic [COORD_W-1:0] top_row;
	} out_beat_t;

	// column step of neighbor k
	function automatic logic [1:0] nb_dc(input logic [2:0] k);
		case (k)
			3'd0, 3'd1, 3'd2: return DIR_NEG;
			3'd3, 3'd4:       return DIR_ZERO;
			default:          return DIR_POS;
		endcase
	endfunction

	// row step of neighbor k
	function automatic logic [1:0] nb_dr(input logic [2:0] k);
		case (k)
			3'd0, 3'd3, 3'd5: return DIR_NEG;
			3'd1, 3'd6:       return DIR_ZERO;
			default:          return DIR_POS;
		endcase
	endfunction

	// orthogonal neighbor sharing the row step of a diagonal
	function automatic logic [2:0] nb_orth_a(input logic [2:0] k);
		case (k)
			3'd0, 3'd5: return 3'd3;
			default:    return 3'd4;
		endcase
	endfunction

	// orthogonal neighbor sharing the column step of a diagonal
	function automatic logic [2:0] nb_orth_b(input logic [2:0] k);
		case (k)
			3'd0, 3'd2: return 3'd1;
			default:    return 3'd6;
		endcase
	endfunction

endpackage

[rtl/core/gcl_stream_if.sv]
// ----------------------------------------------------------------------------
// gcl_stream_if
// valid/ready channel carrying one beat of a given type
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gcl_stream_if #(
	parameter type beat_t = logic
);
	logic  valid;
	logic  ready;
	beat_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/core/grid_component_labeler.sv]
// A host command (cell write, cell label read, region record read) is answered through an
// output register: a write in the next cycle, a read after its memory read in ST_HRD;
// no new command is taken until the answer has left. A label command keeps the block busy:
// a clear sweep over the grid_width x grid_height cells of the label memory, a read and
// check (ST_SRD, ST_SCHK) of each scanned cell, and for every cell taken off the flood queue
// a queue read, eight neighbor reads, one at a time through the single read port of the
// cell and label memories, and eight neighbor updates.
// ----------------------------------------------------------------------------
// grid_component_labeler
// memory based connected region labeler with queue driven flood fill
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_component_labeler_defines.svh"

module grid_component_labeler
	import gcl_pkg::*;
#(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_idx,
	input  logic [DIM_W-1:0]     cfg_wdata,
	gcl_stream_if.sink           req,
	gcl_stream_if.source         rsp
);

	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int CW    = $clog2(MAX_COLS);
	localparam int RWD   = $clog2(MAX_ROWS);
	localparam int AW    = $clog2(CELLS);
	localparam int IDW   = $clog2(CELLS + 1);
	localparam int QW    = CW + RWD;
	localparam int RGW   = 1 + CW + RWD;
	localparam int WE_W  = ($clog2(MAX_COLS + 1) > DIM_W) ? $clog2(MAX_COLS + 1) : DIM_W;
	localparam int HE_W  = ($clog2(MAX_ROWS + 1) > DIM_W) ? $clog2(MAX_ROWS + 1) : DIM_W;
	localparam int CMPW  = (IDW > LBL_W) ? IDW : LBL_W;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_HRD   = 10'b0000000010,
		ST_CLR   = 10'b0000000100,
		ST_SRD   = 10'b0000001000,
		ST_SCHK  = 10'b0000010000,
		ST_POP   = 10'b0000100000,
		ST_PWAIT = 10'b0001000000,
		ST_NBRD  = 10'b0010000000,
		ST_NBFIN = 10'b0100000000,
		ST_NBWR  = 10'b1000000000
	} state_t;

	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c, input logic [RWD-1:0] r);
		return AW'(AW'(c) * AW'(MAX_ROWS)) + AW'(r);
	endfunction

	logic               cell_mem [CELLS];
	logic [IDW-1:0]     lbl_mem  [CELLS];
	logic [RGW-1:0]     reg_mem  [CELLS];
	logic [QW-1:0]      que_mem  [CELLS];

	logic [DIM_W-1:0]   gw_q, gh_q;
	logic [CONN_W-1:0]  oc_q, bc_q;
	state_t             state_q;
	logic [CW-1:0]      c_q, p_c_q;
	logic [RWD-1:0]     r_q, p_r_q;
	logic [IDW-1:0]     id_q, regions_q;
	logic [AW:0]        head_q, tail_q;
	logic               cur_val_q;
	logic [CONN_W-1:0]  mode_q;
	logic [2:0]         k_q, rd_k_s1;
	logic               rd_pend_s1;
	logic [7:0]         nb_in_q, nb_val_q, nb_free_q;
	logic [CW-1:0]      nb_c_q [8];
	logic [RWD-1:0]     nb_r_q [8];
	logic               out_valid_q;
	out_beat_t          out_q;
	op_t                hop_q;
	logic               hstat_q;

	logic               cell_rd_q;
	logic [IDW-1:0]     lbl_rd_q;
	logic [RGW-1:0]     reg_rd_q;
	logic [QW-1:0]      que_rd_q;

	logic [WE_W-1:0]    w_eff;
	logic [HE_W-1:0]    h_eff;
	logic               accept, in_area, rid_ok, last_r, last_c;
	logic [AW-1:0]      host_addr, scan_addr, nb_addr, rd_addr, lbl_waddr;
	logic               lbl_we;
	logic [IDW-1:0]     lbl_wdata;
	logic               nb_ok, take, diag;
	logic [CW-1:0]      nc;
	logic [RWD-1:0]     nr;
	logic [1:0]         dcc, drc;
	logic [CONN_W-1:0]  seed_mode;
	logic               scan_done, out_set;
	out_beat_t          out_nxt;

	always_comb begin
		if (gw_q == '0) begin
			w_eff = WE_W'(1);
		end else if (WE_W'(gw_q) > WE_W'(MAX_COLS)) begin
			w_eff = WE_W'(MAX_COLS);
		end else begin
			w_eff = WE_W'(gw_q);
		end
		if (gh_q == '0) begin
			h_eff = HE_W'(1);
		end else if (HE_W'(gh_q) > HE_W'(MAX_ROWS)) begin
			h_eff = HE_W'(MAX_ROWS);
		end else begin
			h_eff = HE_W'(gh_q);
		end
	end

	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign in_area   = (WE_W'(req.data.col) < w_eff) && (HE_W'(req.data.row) < h_eff);
	assign rid_ok    = (req.data.region_id != '0) &&
		(CMPW'(req.data.region_id) <= CMPW'(regions_q));
	assign host_addr = addr_of(CW'(req.data.col), RWD'(req.data.row));
	assign scan_addr = addr_of(c_q, r_q);
	assign last_r    = HE_W'(r_q) == (h_eff - HE_W'(1));
	assign last_c    = WE_W'(c_q) == (w_eff - WE_W'(1));
	assign scan_done = ((state_q == ST_SCHK && lbl_rd_q != '0) ||
		(state_q == ST_POP && head_q == tail_q)) && last_r && last_c;

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	// neighbor k_q of the cell being expanded
	always_comb begin
		dcc   = nb_dc(k_q);
		drc   = nb_dr(k_q);
		nb_ok = 1'b1;
		nc    = p_c_q;
		nr    = p_r_q;
		case (dcc)
			DIR_NEG: begin
				nb_ok = p_c_q != '0;
				nc    = CW'(p_c_q - 1'b1);
			end
			DIR_POS: begin
				nb_ok = (WE_W'(p_c_q) + WE_W'(1)) < w_eff;
				nc    = CW'(p_c_q + 1'b1);
			end
			default: ;
		endcase
		case (drc)
			DIR_NEG: begin
				nb_ok = nb_ok && (p_r_q != '0);
				nr    = RWD'(p_r_q - 1'b1);
			end
			DIR_POS: begin
				nb_ok = nb_ok && ((HE_W'(p_r_q) + HE_W'(1)) < h_eff);
				nr    = RWD'(p_r_q + 1'b1);
			end
			default: ;
		endcase
		nb_addr = addr_of(nc, nr);
	end

	// decide whether neighbor k_q joins the region
	always_comb begin
		diag = (nb_dc(k_q) != DIR_ZERO) && (nb_dr(k_q) != DIR_ZERO);
		take = nb_in_q[k_q] && (nb_val_q[k_q] == cur_val_q) && nb_free_q[k_q];
		if (diag) begin
			if (mode_q == CONN_FOUR) begin
				take = 1'b0;
			end else if (mode_q == CONN_LIMITED) begin
				take = take && ((nb_val_q[nb_orth_a(k_q)] == cur_val_q) ||
					(nb_val_q[nb_orth_b(k_q)] == cur_val_q));
			end
		end
	end

	always_comb begin
		seed_mode = cell_rd_q ? oc_q : bc_q;
		if (seed_mode == 2'd3) begin
			seed_mode = CONN_EIGHT;
		end
	end

	always_comb begin
		case (state_q)
			ST_SRD:  rd_addr = scan_addr;
			ST_NBRD: rd_addr = nb_addr;
			default: rd_addr = host_addr;
		endcase
	end

	always_comb begin
		lbl_we    = 1'b0;
		lbl_waddr = scan_addr;
		lbl_wdata = '0;
		case (state_q)
			ST_CLR: begin
				lbl_we = 1'b1;
			end
			ST_SCHK: begin
				lbl_we    = lbl_rd_q == '0;
				lbl_wdata = IDW'(id_q + 1'b1);
			end
			ST_NBWR: begin
				lbl_we    = take;
				lbl_waddr = addr_of(nb_c_q[k_q], nb_r_q[k_q]);
				lbl_wdata = id_q;
			end
			default: ;
		endcase
	end

	// answer beat loaded into the output register
	always_comb begin
		out_set              = 1'b0;
		out_nxt              = '0;
		out_nxt.region_count = LBL_W'(regions_q);
		case (state_q)
			ST_IDLE: begin
				if (accept && req.data.operation == OP_WRITE) begin
					out_set        = 1'b1;
					out_nxt.status = !in_area;
				end
			end
			ST_HRD: begin
				out_set        = 1'b1;
				out_nxt.status = hstat_q;
				if (!hstat_q) begin
					if (hop_q == OP_READ_LABEL) begin
						out_nxt.label = LBL_W'(lbl_rd_q);
					end else begin
						out_nxt.region_value = reg_rd_q[RGW-1];
						out_nxt.top_col      = COORD_W'(reg_rd_q[RGW-2:RWD]);
						out_nxt.top_row      = COORD_W'(reg_rd_q[RWD-1:0]);
					end
				end
			end
			ST_SCHK, ST_POP: begin
				if (scan_done) begin
					out_set              = 1'b1;
					out_nxt.region_count = LBL_W'(id_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		cell_rd_q <= cell_mem[rd_addr];
		lbl_rd_q  <= lbl_mem[rd_addr];
		reg_rd_q  <= reg_mem[AW'(req.data.region_id - 1'b1)];
		que_rd_q  <= que_mem[head_q[AW-1:0]];
		if (accept && req.data.operation == OP_WRITE && in_area) begin
			cell_mem[host_addr] <= req.data.cell_value;
		end
		if (lbl_we) begin
			lbl_mem[lbl_waddr] <= lbl_wdata;
		end
		if (state_q == ST_SCHK && lbl_rd_q == '0) begin
			reg_mem[id_q[AW-1:0]] <= {cell_rd_q, c_q, r_q};
			que_mem[0]            <= {c_q, r_q};
		end
		if (state_q == ST_NBWR && take) begin
			que_mem[tail_q[AW-1:0]] <= {nb_c_q[k_q], nb_r_q[k_q]};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_NBRD) begin
			nb_in_q[k_q] <= nb_ok;
			nb_c_q[k_q]  <= nc;
			nb_r_q[k_q]  <= nr;
		end
		if (rd_pend_s1) begin
			nb_val_q[rd_k_s1]  <= cell_rd_q;
			nb_free_q[rd_k_s1] <= lbl_rd_q == '0;
		end
		rd_k_s1 <= k_q;
		if (state_q == ST_SCHK) begin
			cur_val_q <= cell_rd_q;
			mode_q    <= seed_mode;
		end
		if (state_q == ST_PWAIT) begin
			{p_c_q, p_r_q} <= que_rd_q;
		end
		if (accept) begin
			hop_q   <= req.data.operation;
			hstat_q <= (req.data.operation == OP_READ_REGION) ? !rid_ok : !in_area;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q        <= DIM_W'(64);
			gh_q        <= DIM_W'(64);
			oc_q        <= CONN_FOUR;
			bc_q        <= CONN_EIGHT;
			state_q     <= ST_IDLE;
			c_q         <= '0;
			r_q         <= '0;
			id_q        <= '0;
			regions_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			k_q         <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_WIDTH:   gw_q <= cfg_wdata;
					CFG_HEIGHT:  gh_q <= cfg_wdata;
					CFG_OPEN:    oc_q <= cfg_wdata[CONN_W-1:0];
					CFG_BLOCKED: bc_q <= cfg_wdata[CONN_W-1:0];
					default: ;
				endcase
			end
			rd_pend_s1 <= state_q == ST_NBRD;
			if (out_set) begin
				out_valid_q <= 1'b1;
				out_q       <= out_nxt;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.data.operation)
							OP_WRITE: ;
							OP_LABEL: begin
								c_q     <= '0;
								r_q     <= '0;
								state_q <= ST_CLR;
							end
							default: state_q <= ST_HRD;
						endcase
					end
				end
				ST_HRD: begin
					state_q <= ST_IDLE;
				end
				ST_CLR: begin
					if (last_r) begin
						r_q <= '0;
						if (last_c) begin
							c_q     <= '0;
							id_q    <= '0;
							state_q <= ST_SRD;
						end else begin
							c_q <= CW'(c_q + 1'b1);
						end
					end else begin
						r_q <= RWD'(r_q + 1'b1);
					end
				end
				ST_SRD: begin
					state_q <= ST_SCHK;
				end
				ST_SCHK, ST_POP: begin
					if (state_q == ST_SCHK && lbl_rd_q == '0) begin
						id_q    <= IDW'(id_q + 1'b1);
						head_q  <= '0;
						tail_q  <= (AW + 1)'(1);
						state_q <= ST_POP;
					end else if (state_q == ST_POP && head_q != tail_q) begin
						head_q  <= head_q + 1'b1;
						state_q <= ST_PWAIT;
					end else if (last_r) begin
						r_q <= '0;
						if (last_c) begin
							regions_q <= id_q;
							state_q   <= ST_IDLE;
						end else begin
							c_q     <= CW'(c_q + 1'b1);
							state_q <= ST_SRD;
						end
					end else begin
						r_q     <= RWD'(r_q + 1'b1);
						state_q <= ST_SRD;
					end
				end
				ST_PWAIT: begin
					k_q     <= '0;
					state_q <= ST_NBRD;
				end
				ST_NBRD: begin
					if (k_q == 3'd7) begin
						state_q <= ST_NBFIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_NBFIN: begin
					k_q     <= '0;
					state_q <= ST_NBWR;
				end
				ST_NBWR: begin
					if (take) begin
						tail_q <= tail_q + 1'b1;
					end
					if (k_q == 3'd7) begin
						state_q <= ST_POP;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`GCL_ASSERT(a_ready_only_idle, clk, arst_n, !req.ready || state_q == ST_IDLE)
	`GCL_ASSERT(a_queue_order, clk, arst_n, head_q <= tail_q)
	`GCL_ASSERT(a_label_write_states, clk, arst_n, !lbl_we || state_q == ST_CLR || state_q == ST_SCHK || state_q == ST_NBWR)
	`GCL_ASSERT_NEXT(a_pop_reads_queue, clk, arst_n, state_q == ST_POP && head_q != tail_q, state_q == ST_PWAIT)

endmodule
